// ----- rtl/rv32_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_pkg
// Shared sizes, opcodes, state codes and word types for the RV32I executor.
// ----------------------------------------------------------------------------
package rv32_pkg;

    localparam int MEM_BYTES  = 8192;
    localparam int CODE_LIMIT = 4096;
    localparam int MEM_AW     = $clog2(MEM_BYTES);
    localparam int RF_DEPTH   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0]  F7_ALT       = 7'h20;
    localparam logic [4:0]  REG_A0       = 5'd10;
    localparam logic [4:0]  REG_A7       = 5'd17;
    localparam logic [31:0] SVC_EXIT     = 32'd10;
    localparam logic [31:0] UPPER_MASK   = 32'hFFFF_F000;

    typedef enum logic [0:0] {
        KIND_PRELOAD,
        KIND_STEP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [12:0]       load_address;
        logic [7:0]        load_byte;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_RREAD,
        ST_EXEC,
        ST_MEM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] executed_pc;
        logic [31:0] instruction;
        logic        reg_write_en;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        ecall_seen;
        logic [31:0] ecall_service;
        logic [31:0] ecall_argument;
        logic        halted;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/rv32_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rv32_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/rv32_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_front
// Accepts incoming words, tags them as preload or step, queues them.
// ----------------------------------------------------------------------------
module rv32_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic                cmd,
    input  wire logic [12:0]         load_address,
    input  wire logic [7:0]          load_byte,
    output logic                     q_valid,
    output rv32_pkg::item_t          q_item,
    input  wire logic                q_pop
);
    import rv32_pkg::*;

    item_t       ent_reg [QUEUE_DEPTH];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    item_t       in_item;

    assign item_stall = (count_reg == 2'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = ent_reg[0];

    always_comb
    begin
        in_item.kind         = cmd ? KIND_STEP : KIND_PRELOAD;
        in_item.load_address = load_address;
        in_item.load_byte    = load_byte;
        count_next = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg[0] <= (push && count_reg == 2'd1) ? in_item : ent_reg[1];
        end
        else if (push)
        begin
            ent_reg[count_reg[0]] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rv32_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_back
// Sequencer: byte-serial fetch, register read, execute, load/store, result.
// ----------------------------------------------------------------------------
module rv32_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  rv32_pkg::item_t          q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    output rv32_pkg::result_t        out_res,
    input  wire logic                out_stall
);
    import rv32_pkg::*;

    state_t       state_reg, state_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [31:0]  pc_reg, pc_next;
    logic         halt_reg, halt_next;
    logic [31:0]  instr_reg, instr_next;
    logic [31:0]  addr_reg, addr_next;
    logic [31:0]  b_reg, b_next;
    logic [31:0]  rfv_reg, rfv_next;
    result_t      res_reg, res_next;
    logic         ovalid_reg, ovalid_next;
    result_t      ores_reg, ores_next;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              rf_we;
    logic [4:0]        rf_waddr, rf_ra1, rf_ra2;
    logic [31:0]       rf_wdata, rf_rd1, rf_rd2;

    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [31:0] a, b, immi, imms, immb, immj, val, next_pc, ld, ldx;
    logic        wr, take;
    logic [2:0]  nbytes;
    logic [1:0]  bidx;

    rv32_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    rv32_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf1 (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_ra1), .rdata(rf_rd1)
    );

    rv32_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf2 (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_ra2), .rdata(rf_rd2)
    );

    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;

    always_comb
    begin
        op   = instr_reg[6:0];
        rd   = instr_reg[11:7];
        f3   = instr_reg[14:12];
        rs1  = instr_reg[19:15];
        rs2  = instr_reg[24:20];
        f7   = instr_reg[31:25];
        immi = {{20{instr_reg[31]}}, instr_reg[31:20]};
        imms = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
        immb = {{19{instr_reg[31]}}, instr_reg[31], instr_reg[7], instr_reg[30:25],
                instr_reg[11:8], 1'b0};
        immj = {{11{instr_reg[31]}}, instr_reg[31], instr_reg[19:12], instr_reg[20],
                instr_reg[30:21], 1'b0};
        rf_ra1 = (op == OP_SYSTEM) ? REG_A7 : rs1;
        rf_ra2 = (op == OP_SYSTEM) ? REG_A0 : rs2;
        a = rfv_reg[rf_ra1] ? rf_rd1 : 32'd0;
        b = rfv_reg[rf_ra2] ? rf_rd2 : 32'd0;
        case (f3[1:0])
            2'd0:    nbytes = 3'd1;
            2'd1:    nbytes = 3'd2;
            default: nbytes = 3'd4;
        endcase
        bidx = 2'(cnt_reg - 3'd1);

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        instr_next  = instr_reg;
        addr_next   = addr_reg;
        b_next      = b_reg;
        rfv_next    = rfv_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && out_stall;
        ores_next   = ores_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = MEM_AW'(addr_reg + 32'(cnt_reg));
        mem_wdata   = b_reg[8*cnt_reg[1:0] +: 8];
        mem_raddr   = MEM_AW'(addr_reg + 32'(cnt_reg));
        rf_we       = 1'b0;
        rf_waddr    = rd;
        rf_wdata    = 32'd0;
        val         = 32'd0;
        wr          = 1'b0;
        take        = 1'b0;
        next_pc     = pc_reg + 32'd4;
        ld          = b_reg;
        ldx         = 32'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    res_next = '0;
                    cnt_next = 3'd0;
                    if (q_item.kind == KIND_PRELOAD)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = MEM_AW'(q_item.load_address);
                        mem_wdata  = q_item.load_byte;
                        state_next = ST_DONE;
                    end
                    else if (halt_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (next_pc >= 32'(CODE_LIMIT))
                    begin
                        pc_next    = next_pc;
                        halt_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                mem_raddr = MEM_AW'(pc_reg + 32'(cnt_reg));
                if (cnt_reg != 3'd0)
                begin
                    instr_next = {mem_rdata, instr_reg[31:8]};
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = ST_RREAD;
                end
            end
            ST_RREAD:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                res_next.executed_pc = pc_reg;
                res_next.instruction = instr_reg;
                cnt_next   = 3'd0;
                state_next = ST_DONE;
                case (op)
                    OP_REG:
                    begin
                        wr = 1'b1;
                        case (f3)
                            3'd0: val = (f7 == F7_ALT) ? a - b : a + b;
                            3'd1: val = a << b[4:0];
                            3'd2: val = 32'($signed(a) < $signed(b));
                            3'd3: val = 32'(a < b);
                            3'd4: val = a ^ b;
                            3'd5: val = (f7 == F7_ALT) ? 32'($signed(a) >>> b[4:0])
                                                       : a >> b[4:0];
                            3'd6: val = a | b;
                            default: val = a & b;
                        endcase
                    end
                    OP_IMM:
                    begin
                        wr = 1'b1;
                        case (f3)
                            3'd0: val = a + immi;
                            3'd1: val = a << rs2;
                            3'd2: val = 32'($signed(a) < $signed(immi));
                            3'd3: val = 32'(a < immi);
                            3'd4: val = a ^ immi;
                            3'd5: val = (f7 == F7_ALT) ? 32'($signed(a) >>> rs2) : a >> rs2;
                            3'd6: val = a | immi;
                            default: val = a & immi;
                        endcase
                    end
                    OP_LOAD:
                    begin
                        if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7)
                        begin
                            addr_next  = a + immi;
                            state_next = ST_MEM;
                        end
                    end
                    OP_STORE:
                    begin
                        if (f3 <= 3'd2)
                        begin
                            addr_next  = a + imms;
                            b_next     = b;
                            state_next = ST_MEM;
                        end
                    end
                    OP_BRANCH:
                    begin
                        case (f3)
                            3'd0: take = (a == b);
                            3'd1: take = (a != b);
                            3'd4: take = ($signed(a) < $signed(b));
                            3'd5: take = !($signed(a) < $signed(b));
                            3'd6: take = (a < b);
                            3'd7: take = (a >= b);
                            default: take = 1'b0;
                        endcase
                        if (take)
                        begin
                            next_pc = pc_reg + immb;
                        end
                    end
                    OP_LUI:
                    begin
                        wr  = 1'b1;
                        val = instr_reg & UPPER_MASK;
                    end
                    OP_AUIPC:
                    begin
                        wr  = 1'b1;
                        val = (instr_reg & UPPER_MASK) + pc_reg;
                    end
                    OP_JAL:
                    begin
                        wr      = 1'b1;
                        val     = pc_reg + 32'd4;
                        next_pc = pc_reg + immj;
                    end
                    OP_JALR:
                    begin
                        wr      = 1'b1;
                        val     = pc_reg + 32'd4;
                        next_pc = (a + immi) & ~32'd1;
                    end
                    OP_SYSTEM:
                    begin
                        res_next.ecall_seen     = 1'b1;
                        res_next.ecall_service  = a;
                        res_next.ecall_argument = b;
                        if (a == SVC_EXIT)
                        begin
                            halt_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        wr = 1'b0;
                    end
                endcase
                pc_next = next_pc;
                if (wr && rd != 5'd0)
                begin
                    rf_we                 = 1'b1;
                    rf_wdata              = val;
                    rfv_next[rd]          = 1'b1;
                    res_next.reg_write_en = 1'b1;
                    res_next.reg_index    = rd;
                    res_next.reg_value    = val;
                end
            end
            ST_MEM:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (op == OP_STORE)
                begin
                    mem_we = 1'b1;
                    if (cnt_reg == nbytes - 3'd1)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if (cnt_reg != 3'd0)
                    begin
                        ld[8*bidx +: 8] = mem_rdata;
                    end
                    b_next = ld;
                    if (cnt_reg == nbytes)
                    begin
                        case (f3)
                            3'd0:    ldx = {{24{ld[7]}}, ld[7:0]};
                            3'd1:    ldx = {{16{ld[15]}}, ld[15:0]};
                            3'd4:    ldx = {24'd0, ld[7:0]};
                            3'd5:    ldx = {16'd0, ld[15:0]};
                            default: ldx = ld;
                        endcase
                        if (rd != 5'd0)
                        begin
                            rf_we                 = 1'b1;
                            rf_wdata              = ldx;
                            rfv_next[rd]          = 1'b1;
                            res_next.reg_write_en = 1'b1;
                            res_next.reg_index    = rd;
                            res_next.reg_value    = ldx;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next      = 1'b1;
                    ores_next        = res_reg;
                    ores_next.halted = halt_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 3'd0;
            pc_reg     <= 32'd0;
            halt_reg   <= 1'b0;
            rfv_reg    <= 32'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pc_reg     <= pc_next;
            halt_reg   <= halt_next;
            rfv_reg    <= rfv_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg <= instr_next;
        addr_reg  <= addr_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        ores_reg  <= ores_next;
    end

endmodule
`default_nettype wire

// ----- rtl/rv32i_instruction_executor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_instruction_executor
// RV32I base integer core driven one word at a time: preload or step.
// ----------------------------------------------------------------------------
// A preload word writes one byte into memory. A step fetches and executes one
// instruction; loads and stores take longer than ALU, branch, jump and ECALL
// instructions. This is set by the single byte-wide memory: the fetch reads
// four bytes one per cycle and loads and stores move one byte per cycle. A
// two-word queue at the input and a result register at the output let the
// next word be taken while a result still waits. Reading memory that was
// never preloaded or stored gives undefined data.
module rv32i_instruction_executor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        cmd,
    input  wire logic [12:0] load_address,
    input  wire logic [7:0]  load_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      executed_pc,
    output logic [31:0]      instruction,
    output logic             reg_write_en,
    output logic [4:0]       reg_index,
    output logic [31:0]      reg_value,
    output logic             ecall_seen,
    output logic [31:0]      ecall_service,
    output logic [31:0]      ecall_argument,
    output logic             halted
);
    import rv32_pkg::*;

    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t res;

    rv32_front u_front (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .cmd(cmd), .load_address(load_address), .load_byte(load_byte),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    rv32_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .out_valid(result_valid), .out_res(res), .out_stall(result_stall)
    );

    assign executed_pc    = res.executed_pc;
    assign instruction    = res.instruction;
    assign reg_write_en   = res.reg_write_en;
    assign reg_index      = res.reg_index;
    assign reg_value      = res.reg_value;
    assign ecall_seen     = res.ecall_seen;
    assign ecall_service  = res.ecall_service;
    assign ecall_argument = res.ecall_argument;
    assign halted         = res.halted;

endmodule
`default_nettype wire
